// File: src/lsm_pkg.sv
// Package for the LCD serial link master: codes, result types and constants.
`default_nettype none
package lsm_pkg;

	// Poll counter and poll limit widths
	localparam int POLL_COUNT_WIDTH = 20;
	localparam int POLL_LIMIT_W     = 20;
	localparam int CMP_W = (POLL_COUNT_WIDTH > POLL_LIMIT_W) ? POLL_COUNT_WIDTH : POLL_LIMIT_W;
	localparam logic [POLL_LIMIT_W-1:0] POLL_LIMIT_RST = POLL_LIMIT_W'(100000);

	// Output queue: room for one item's full burst plus one in flight
	localparam int MAX_RES = 3;
	localparam int QDEPTH  = 4;
	localparam int QCW     = $clog2(QDEPTH + 1);

	// Link bytes
	localparam logic [7:0] BYTE_POLL     = 8'hFC;
	localparam logic [7:0] BYTE_SYNC_CMD = 8'hF8;
	localparam logic [7:0] BYTE_SYNC_DAT = 8'hFA;
	localparam logic [7:0] BYTE_SYNC_RD  = 8'hFE;
	localparam logic [7:0] BUSY_MASK     = 8'h80;
	localparam logic [7:0] HI_MASK       = 8'hF0;
	localparam logic [7:0] LO_MASK       = 8'h0F;

	typedef enum logic [1:0] {
		REQ_WR_CMD = 2'd0,
		REQ_WR_DAT = 2'd1,
		REQ_RD_DAT = 2'd2,
		REQ_RX     = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		KIND_TX      = 2'd0,
		KIND_DATA    = 2'd1,
		KIND_TIMEOUT = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_BUSY_RX = 3'd1,
		PH_READ_RX = 3'd2
	} phase_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       last;
	} result_t;

	// Results of one processed item, packed from position 0
	typedef struct packed {
		logic [1:0]              cnt;
		result_t [MAX_RES-1:0]   res;
	} step_out_t;

endpackage
`default_nettype wire

// File: src/lcd_serial_link_master.sv
// Items wait in the input register; results are registered in the queue.
// Throughput: with out_stall low, one item per cycle while items yield at most
//   one result, and results leave a four-entry queue one per cycle; an item is
//   held in the input register until the queue has room for three results.
// Reset: arst_n clears state to idle, empties the queue, poll_limit to 100000.
// Top level of the LCD serial link master.
`default_nettype none
module lcd_serial_link_master (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [1:0]                       req_type,
	input  wire logic [7:0]                       data_byte,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [lsm_pkg::POLL_LIMIT_W-1:0] cfg_data,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [1:0]                            out_kind,
	output logic [7:0]                            out_byte,
	output logic                                  last
);
	import lsm_pkg::*;

	step_out_t step;
	result_t   head;
	logic      room;

	assign cfg_ready = 1'b1;

	lsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.data_byte (data_byte),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.room      (room),
		.step      (step)
	);

	lsm_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign out_kind = head.kind;
	assign out_byte = head.data;
	assign last     = head.last;

endmodule
`default_nettype wire

// File: src/lsm_ctrl.sv
// Input register and request/poll sequencing for the LCD serial link master.
`default_nettype none
module lsm_ctrl (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [1:0]                       req_type,
	input  wire logic [7:0]                       data_byte,
	input  wire logic                             cfg_we,
	input  wire logic [lsm_pkg::POLL_LIMIT_W-1:0] cfg_data,
	input  wire logic                             room,
	output lsm_pkg::step_out_t                    step
);
	import lsm_pkg::*;

	logic                        valid_s1;
	logic [1:0]                  req_s1;
	logic [7:0]                  byte_s1;
	logic                        in_acc;
	logic                        fire;

	phase_t                      phase_q, phase_d;
	logic [1:0]                  op_q, op_d;
	logic [7:0]                  pbyte_q, pbyte_d;
	logic [7:0]                  first_q, first_d;
	logic                        rxi_q, rxi_d;
	logic [POLL_COUNT_WIDTH-1:0] pcnt_q, pcnt_d;
	logic [POLL_LIMIT_W-1:0]     limit_q;

	logic                        do_poll;
	logic [POLL_COUNT_WIDTH-1:0] poll_c;
	logic [7:0]                  joined;

	// Input register handshake
	assign fire     = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_s1  <= req_type;
			byte_s1 <= data_byte;
		end
	end

	assign joined = (first_q & HI_MASK) | (byte_s1 & LO_MASK);

	// Step logic: state update and up to three results
	always_comb begin
		phase_d  = phase_q;
		op_d     = op_q;
		pbyte_d  = pbyte_q;
		first_d  = first_q;
		rxi_d    = rxi_q;
		pcnt_d   = pcnt_q;
		do_poll  = 1'b0;
		poll_c   = pcnt_q;
		step.cnt = 2'd0;
		step.res = '0;

		if (fire) begin
			if (req_s1 != REQ_RX) begin
				if (phase_q == PH_IDLE) begin
					op_d    = req_s1;
					pbyte_d = byte_s1;
					do_poll = 1'b1;
					poll_c  = '0;
				end
			end else if (phase_q != PH_IDLE) begin
				if (!rxi_q) begin
					first_d = byte_s1;
					rxi_d   = 1'b1;
				end else begin
					rxi_d = 1'b0;
					if (phase_q == PH_READ_RX) begin
						step.cnt    = 2'd1;
						step.res[0] = '{kind: KIND_DATA, data: joined, last: 1'b1};
						phase_d     = PH_IDLE;
					end else if ((joined & BUSY_MASK) != 8'h00) begin
						do_poll = 1'b1;
					end else if (op_q == REQ_RD_DAT) begin
						step.cnt    = 2'd1;
						step.res[0] = '{kind: KIND_TX, data: BYTE_SYNC_RD, last: 1'b0};
						phase_d     = PH_READ_RX;
					end else begin
						step.cnt    = 2'd3;
						step.res[0] = '{kind: KIND_TX,
							data: (op_q == REQ_WR_CMD) ? BYTE_SYNC_CMD : BYTE_SYNC_DAT,
							last: 1'b0};
						step.res[1] = '{kind: KIND_TX, data: pbyte_q & HI_MASK, last: 1'b0};
						step.res[2] = '{kind: KIND_TX, data: {pbyte_q[3:0], 4'h0},
							last: 1'b1};
						phase_d     = PH_IDLE;
					end
				end
			end

			// Busy poll with timeout check
			if (do_poll) begin
				step.res[0] = '{kind: KIND_TX, data: BYTE_POLL, last: 1'b0};
				rxi_d       = 1'b0;
				if (CMP_W'(poll_c) > CMP_W'(limit_q)) begin
					step.cnt    = 2'd2;
					step.res[1] = '{kind: KIND_TIMEOUT, data: 8'h00, last: 1'b1};
					phase_d     = PH_IDLE;
					pcnt_d      = poll_c;
				end else begin
					step.cnt = 2'd1;
					phase_d  = PH_BUSY_RX;
					pcnt_d   = (poll_c == '1) ? poll_c : poll_c + 1'b1;
				end
			end
		end
	end

	// State and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			op_q    <= '0;
			pbyte_q <= '0;
			first_q <= '0;
			rxi_q   <= 1'b0;
			pcnt_q  <= '0;
			limit_q <= POLL_LIMIT_RST;
		end else begin
			phase_q <= phase_d;
			op_q    <= op_d;
			pbyte_q <= pbyte_d;
			first_q <= first_d;
			rxi_q   <= rxi_d;
			pcnt_q  <= pcnt_d;
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
		end
	end

endmodule
`default_nettype wire

// File: src/lsm_outq.sv
// Result queue: takes a burst of up to three results, issues one per transaction.
`default_nettype none
module lsm_outq (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lsm_pkg::step_out_t step,
	output logic                    room,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output lsm_pkg::result_t        head
);
	import lsm_pkg::*;

	result_t        slot_q [QDEPTH];
	result_t        slot_d [QDEPTH];
	logic [QCW-1:0] cnt_q, cnt_d, cnt_pop;
	logic           pop;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && !out_stall;
	assign head      = slot_q[0];
	// A full burst fits whatever the output side does this cycle
	assign room      = (cnt_q <= QCW'(QDEPTH - MAX_RES));
	assign cnt_pop   = cnt_q - QCW'(pop);
	assign cnt_d     = cnt_pop + QCW'(step.cnt);

	// Shift on pop, append the new burst behind the survivors
	always_comb begin
		logic [QCW-1:0] off;
		for (int i = 0; i < QDEPTH; i++) begin
			off       = QCW'(i) - cnt_pop;
			slot_d[i] = slot_q[i];
			if (QCW'(i) < cnt_pop) begin
				if (pop && i < QDEPTH - 1) begin
					slot_d[i] = slot_q[(i < QDEPTH - 1) ? i + 1 : i];
				end
			end else if (off < QCW'(step.cnt)) begin
				slot_d[i] = step.res[off[1:0]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QDEPTH; i++) begin
			slot_q[i] <= slot_d[i];
		end
	end

endmodule
`default_nettype wire

// File: src/lsm_checker.sv
// Port-level checks for the LCD serial link master, bound to the top level.
`default_nettype none
module lsm_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [1:0] out_kind,
	input wire logic [7:0] out_byte,
	input wire logic       last
);
	import lsm_pkg::*;

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable({out_kind, out_byte, last}))
		else $error("stalled result changed");

	// Timeout closes the request with a zero byte
	a_tmo: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_TIMEOUT |-> last && out_byte == 8'h00)
		else $error("bad timeout result");

	// Read data always closes the request
	a_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_DATA |-> last)
		else $error("read data not last");

	// A closing transmit byte is a shifted low nibble
	a_lo: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_TX && last |-> out_byte[3:0] == 4'h0)
		else $error("bad closing transmit byte");

endmodule

bind lcd_serial_link_master lsm_checker u_lsm_checker (.*);
`default_nettype wire
